### rtl/core/pic_pkg.sv
// Shared constants, types and a helper function of the perceptron insertion cache policy.
package pic_pkg;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int TABLE_SIZE  = 1024;
    localparam int HISTORY_LEN = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int FEATURES    = 3;
    localparam int PC_SHIFT    = 2;

    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_W   = $clog2(WAYS);
    localparam int TBL_W   = $clog2(TABLE_SIZE);
    localparam int QAGE_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ADDR_W  = 58;
    localparam int PC_W    = 12;
    localparam int WGT_W   = 5;
    localparam int SUM_W   = WGT_W + 2;
    localparam int CLEAR_LEN = (SETS > TABLE_SIZE) ? SETS : TABLE_SIZE;
    localparam int CLR_W   = $clog2(CLEAR_LEN);

    localparam logic [1:0] ACT_VICTIM = 2'd0;
    localparam logic [1:0] ACT_HIT    = 2'd1;
    localparam logic [1:0] ACT_FILL   = 2'd2;

    localparam logic [1:0] CFG_SUM_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_MIDDLE_POSITION = 2'd2;

    localparam logic [1:0] CLS_NEUTRAL = 2'b00;
    localparam logic [1:0] CLS_REUSED  = 2'b01;
    localparam logic [1:0] CLS_DEAD    = 2'b11;

    typedef logic [WAY_W-1:0] age_t;
    typedef logic [FEATURES-1:0][TBL_W-1:0] fidx_t;
    typedef logic signed [WGT_W-1:0] weight_t;

    typedef struct packed {
        age_t [WAYS-1:0]       age;
        logic [WAYS-1:0]       nr;
        logic [WAYS-1:0][1:0]  pred;
        fidx_t [WAYS-1:0]      fi;
    } set_row_t;

    typedef logic [WAYS-1:0][ADDR_W-1:0] tag_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        fidx_t             idx;
        logic [QAGE_W-1:0] age;
    } vq_slot_t;

    typedef vq_slot_t [QUEUE_DEPTH-1:0] vq_row_t;

    // Saturating step of one weight; a weight beyond the bound only moves toward it.
    function automatic weight_t train_weight(weight_t w, logic up, logic [3:0] lim);
        weight_t lim_s;
        weight_t res;
        lim_s = weight_t'({1'b0, lim});
        res   = w;
        if (up && (w < lim_s)) begin
            res = w + weight_t'(1);
        end else if (!up && (w > -lim_s)) begin
            res = w - weight_t'(1);
        end
        return res;
    endfunction

endpackage

### rtl/core/perceptron_insertion_cache_replacement.sv
// Top level: LRU age stacks per set with perceptron-chosen insertion depth.
// Victim query, hit and undefined actions: the result is registered from ST_LOAD, then idle.
// Fill: states ST_LOAD, ST_W1, ST_W2R, ST_W2, ST_W3R, ST_W3; the three weight memories each take
// a read-modify-write for the evicted line, for a victim queue match and a read to predict.
// After reset a clearing pass over 2048 addresses initializes set, queue and weight memories;
// no item is accepted during it, configuration writes are taken at all times.
module perceptron_insertion_cache_replacement (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [10:0]                 s_set_index,
    input  logic [3:0]                  s_way_index,
    input  logic [57:0]                 s_line_address,
    input  logic [11:0]                 s_program_counter,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [3:0]                  m_victim_way,
    output logic signed [1:0]           m_predicted_class,
    output logic [3:0]                  m_insert_depth,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [4:0]                  cfg_data
);
    import pic_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_W1    = 8'b0000_1000,
        ST_W2R   = 8'b0001_0000,
        ST_W2    = 8'b0010_0000,
        ST_W3R   = 8'b0100_0000,
        ST_W3    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg;

    logic [1:0]        act_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [HISTORY_LEN-1:0][PC_W-1:0] hist_reg;

    logic [4:0] thr_reg;
    logic [3:0] lim_reg;
    logic [3:0] mid_reg;

    logic  q_hit_reg, q_hit_next;
    fidx_t q_idx_reg, q_idx_next;

    logic             m_valid_reg;
    logic [WAY_W-1:0] victim_reg;
    logic [1:0]       cls_reg;
    logic [WAY_W-1:0] depth_reg;

    logic             res_load;
    logic [WAY_W-1:0] res_victim;
    logic [1:0]       res_cls;
    logic [WAY_W-1:0] res_depth;

    logic accept, out_free;

    // Memories
    logic             set_we, set_re;
    logic [SET_W-1:0] set_waddr;
    set_row_t         set_wdata, set_rdata;
    logic             tag_we;
    tag_row_t         tag_wdata, tag_rdata;
    logic             vq_we;
    logic [SET_W-1:0] vq_waddr;
    vq_row_t          vq_wdata, vq_rdata;
    logic             w_we, w_re;
    logic [FEATURES-1:0][TBL_W-1:0] w_waddr, w_raddr;
    weight_t [FEATURES-1:0] w_wdata, w_rdata;

    // Per-item decode
    logic              nr_e, enq, train_dn, train_up_e;
    logic [1:0]        pred_e;
    fidx_t             fi_e, fi_new;
    vq_row_t           vq_new;
    logic [PC_W-1:0]   hx;
    logic signed [SUM_W-1:0] sum, thr_s;
    logic [1:0]        cls;
    logic [WAY_W-1:0]  depth, victim;
    set_row_t          row_hit, row_fill, row_clr;
    tag_row_t          tag_new;
    vq_row_t           vq_clr;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_victim_way      = victim_reg;
    assign m_predicted_class = cls_reg;
    assign m_insert_depth    = depth_reg;

    pic_ram #(.WIDTH($bits(set_row_t)), .DEPTH(SETS)) u_set_ram (
        .aclk(aclk), .we(set_we), .waddr(set_waddr), .wdata(set_wdata),
        .re(set_re), .raddr(s_set_index[SET_W-1:0]), .rdata(set_rdata)
    );

    pic_ram #(.WIDTH($bits(tag_row_t)), .DEPTH(SETS)) u_tag_ram (
        .aclk(aclk), .we(tag_we), .waddr(set_reg), .wdata(tag_wdata),
        .re(set_re), .raddr(s_set_index[SET_W-1:0]), .rdata(tag_rdata)
    );

    pic_ram #(.WIDTH($bits(vq_row_t)), .DEPTH(SETS)) u_vq_ram (
        .aclk(aclk), .we(vq_we), .waddr(vq_waddr), .wdata(vq_wdata),
        .re(set_re), .raddr(s_set_index[SET_W-1:0]), .rdata(vq_rdata)
    );

    for (genvar f = 0; f < FEATURES; f++) begin : g_wgt
        pic_ram #(.WIDTH(WGT_W), .DEPTH(TABLE_SIZE)) u_wgt_ram (
            .aclk(aclk), .we(w_we), .waddr(w_waddr[f]), .wdata(w_wdata[f]),
            .re(w_re), .raddr(w_raddr[f]), .rdata(w_rdata[f])
        );
    end

    // Evicted line's training decision and the victim queue after a possible enqueue.
    always_comb begin
        nr_e       = set_rdata.nr[way_reg];
        pred_e     = set_rdata.pred[way_reg];
        fi_e       = set_rdata.fi[way_reg];
        enq        = nr_e && (pred_e == CLS_DEAD);
        train_dn   = nr_e && !enq;
        train_up_e = !nr_e && (pred_e != CLS_REUSED);

        vq_new = vq_rdata;
        if (enq) begin
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                if (int'(vq_rdata[k].age) >= QUEUE_DEPTH - 1) begin
                    vq_new[k].age  = '0;
                    vq_new[k].addr = tag_rdata[way_reg];
                    vq_new[k].idx  = fi_e;
                end else begin
                    vq_new[k].age = vq_rdata[k].age + QAGE_W'(1);
                end
            end
        end

        // Reverse scan so the lowest matching slot wins.
        q_hit_next = 1'b0;
        q_idx_next = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (vq_new[k].addr == addr_reg) begin
                q_hit_next = 1'b1;
                q_idx_next = vq_new[k].idx;
            end
        end
    end

    // Features, perceptron sum and insertion decision for the filled line.
    always_comb begin
        hx = '0;
        for (int h = 0; h < HISTORY_LEN; h++) begin
            hx = hx ^ hist_reg[h];
        end
        fi_new[0] = addr_reg[TBL_W-1:0];
        fi_new[1] = TBL_W'(32'(pc_reg) >> PC_SHIFT);
        fi_new[2] = TBL_W'(32'(hx) >> PC_SHIFT);

        sum = SUM_W'(w_rdata[0]) + SUM_W'(w_rdata[1]) + SUM_W'(w_rdata[2]);
        thr_s = SUM_W'({2'b00, thr_reg});
        if (sum < -thr_s) begin
            cls   = CLS_DEAD;
            depth = WAY_W'(WAYS - 1);
        end else if (sum > thr_s) begin
            cls   = CLS_REUSED;
            depth = '0;
        end else begin
            cls   = CLS_NEUTRAL;
            depth = (int'(mid_reg) > WAYS - 1) ? WAY_W'(WAYS - 1) : WAY_W'(mid_reg);
        end
    end

    // Age stack updates for hit and fill, victim search and clearing values.
    always_comb begin
        age_t old_age;
        age_t a;
        old_age = set_rdata.age[way_reg];

        row_hit = set_rdata;
        for (int i = 0; i < WAYS; i++) begin
            if (set_rdata.age[i] < old_age) begin
                row_hit.age[i] = set_rdata.age[i] + age_t'(1);
            end
        end
        row_hit.age[way_reg] = '0;
        row_hit.nr[way_reg]  = 1'b0;

        // The filled way leaves the stack first, then re-enters at its depth.
        row_fill = set_rdata;
        for (int i = 0; i < WAYS; i++) begin
            a = set_rdata.age[i];
            if (a > old_age) begin
                a = a - age_t'(1);
            end
            if (a >= depth) begin
                a = a + age_t'(1);
            end
            row_fill.age[i] = a;
        end
        row_fill.age[way_reg]  = depth;
        row_fill.pred[way_reg] = cls;
        row_fill.nr[way_reg]   = 1'b1;
        row_fill.fi[way_reg]   = fi_new;

        tag_new = tag_rdata;
        tag_new[way_reg] = addr_reg;

        victim = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (int'(set_rdata.age[i]) == WAYS - 1) begin
                victim = WAY_W'(i);
            end
        end

        row_clr = '0;
        for (int i = 0; i < WAYS; i++) begin
            row_clr.age[i] = WAY_W'(i);
        end
        row_clr.nr = '1;

        vq_clr = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            vq_clr[k].age = QAGE_W'(k);
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        set_re     = accept;
        set_we     = 1'b0;
        set_waddr  = set_reg;
        set_wdata  = row_hit;
        tag_we     = 1'b0;
        tag_wdata  = tag_new;
        vq_we      = 1'b0;
        vq_waddr   = set_reg;
        vq_wdata   = vq_new;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = fi_e;
        w_raddr    = fi_e;
        w_wdata    = '0;
        res_load   = 1'b0;
        res_victim = '0;
        res_cls    = CLS_NEUTRAL;
        res_depth  = '0;

        case (state_reg)
            ST_CLEAR: begin
                set_we    = (int'(clr_cnt_reg) < SETS);
                set_waddr = clr_cnt_reg[SET_W-1:0];
                set_wdata = row_clr;
                vq_we     = (int'(clr_cnt_reg) < SETS);
                vq_waddr  = clr_cnt_reg[SET_W-1:0];
                vq_wdata  = vq_clr;
                w_we      = (int'(clr_cnt_reg) < TABLE_SIZE);
                for (int f = 0; f < FEATURES; f++) begin
                    w_waddr[f] = clr_cnt_reg[TBL_W-1:0];
                end
                if (int'(clr_cnt_reg) == CLEAR_LEN - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                case (act_reg)
                    ACT_VICTIM: begin
                        if (out_free) begin
                            res_load   = 1'b1;
                            res_victim = victim;
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_HIT: begin
                        if (out_free) begin
                            set_we     = 1'b1;
                            set_wdata  = row_hit;
                            tag_we     = 1'b1;
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    ACT_FILL: begin
                        vq_we      = enq;
                        w_re       = 1'b1;
                        w_raddr    = fi_e;
                        state_next = ST_W1;
                    end
                    default: begin
                        if (out_free) begin
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_W1: begin
                w_we    = train_dn || train_up_e;
                w_waddr = fi_e;
                for (int f = 0; f < FEATURES; f++) begin
                    w_wdata[f] = train_weight(w_rdata[f], train_up_e, lim_reg);
                end
                state_next = ST_W2R;
            end
            ST_W2R: begin
                w_re       = 1'b1;
                w_raddr    = q_idx_reg;
                state_next = ST_W2;
            end
            ST_W2: begin
                w_we    = q_hit_reg;
                w_waddr = q_idx_reg;
                for (int f = 0; f < FEATURES; f++) begin
                    w_wdata[f] = train_weight(w_rdata[f], 1'b1, lim_reg);
                end
                state_next = ST_W3R;
            end
            ST_W3R: begin
                w_re       = 1'b1;
                w_raddr    = fi_new;
                state_next = ST_W3;
            end
            ST_W3: begin
                if (out_free) begin
                    set_we     = 1'b1;
                    set_wdata  = row_fill;
                    tag_we     = 1'b1;
                    res_load   = 1'b1;
                    res_cls    = cls;
                    res_depth  = depth;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            hist_reg    <= '0;
            thr_reg     <= 5'd8;
            lim_reg     <= 4'd8;
            mid_reg     <= 4'd7;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (accept && ((s_action == ACT_HIT) || (s_action == ACT_FILL))) begin
                for (int h = HISTORY_LEN - 1; h > 0; h--) begin
                    hist_reg[h] <= hist_reg[h-1];
                end
                hist_reg[0] <= s_program_counter;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SUM_THRESHOLD:   thr_reg <= cfg_data;
                    CFG_WEIGHT_LIMIT:    lim_reg <= cfg_data[3:0];
                    CFG_MIDDLE_POSITION: mid_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_action;
            set_reg  <= s_set_index[SET_W-1:0];
            way_reg  <= s_way_index[WAY_W-1:0];
            addr_reg <= s_line_address;
            pc_reg   <= s_program_counter;
        end
        if (state_reg == ST_LOAD) begin
            q_hit_reg <= q_hit_next;
            q_idx_reg <= q_idx_next;
        end
        if (res_load) begin
            victim_reg <= res_victim;
            cls_reg    <= res_cls;
            depth_reg  <= res_depth;
        end
    end

endmodule

### rtl/core/pic_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/pic_checker.sv
// Port-level checker for the perceptron insertion cache policy, bound to the top level.
module pic_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [1:0]        s_action,
    input logic [10:0]       s_set_index,
    input logic [3:0]        s_way_index,
    input logic [57:0]       s_line_address,
    input logic [11:0]       s_program_counter,
    input logic              m_valid,
    input logic              m_ready,
    input logic [3:0]        m_victim_way,
    input logic signed [1:0] m_predicted_class,
    input logic [3:0]        m_insert_depth,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [1:0]        cfg_index,
    input logic [4:0]        cfg_data
);
    import pic_pkg::*;

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_victim_way)
            && $stable(m_predicted_class) && $stable(m_insert_depth))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while busy");

    // A named victim comes only from a victim query, which carries no prediction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_victim_way != 4'd0) |-> (m_predicted_class == 2'sb00)
            && (m_insert_depth == 4'd0))
        else $error("victim result with prediction fields");

    // A reused prediction inserts at the top of the stack.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_predicted_class == 2'sb01) |-> (m_insert_depth == 4'd0))
        else $error("reused line not inserted at top");

    // A dead prediction inserts at the bottom; the code two is never produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_predicted_class[1] == 1'b1) |-> (m_predicted_class == 2'sb11)
            && (int'(m_insert_depth) == WAYS - 1))
        else $error("dead line not inserted at bottom");

endmodule

bind perceptron_insertion_cache_replacement pic_checker u_pic_checker (.*);
